[rtl/ccedf_pkg.sv]
package ccedf_pkg;

    // default geometry
    localparam int COLUMN_LEN_DEF = 32;
    localparam int OUT_LEN_DEF    = 16;

    // register indexes
    localparam int REG_MIN_DENSITY = 0;
    localparam int REG_FINAL_PASS  = 1;

    // input commands
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // queued operation kinds
    typedef enum logic [1:0] {
        OP_COEF   = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_RUN    = 2'd2
    } op_kind_t;

    typedef struct packed {
        op_kind_t    kind;
        logic [31:0] re;
        logic [31:0] im;
    } op_t;

    // one row result handed to the floor unit
    typedef struct packed {
        logic [31:0] re;
        logic [31:0] im;
        logic [3:0]  index;
        logic        last;
    } row_res_t;

endpackage

[rtl/ccedf_front.sv]
module ccedf_front
    import ccedf_pkg::*;
#(
    parameter int COLUMN_LEN = COLUMN_LEN_DEF,
    parameter int OUT_LEN    = OUT_LEN_DEF,
    parameter int CA_W       = $clog2(OUT_LEN * COLUMN_LEN)
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_ready,
    input  logic            command,
    input  logic [3:0]      row_index,
    input  logic [4:0]      position,
    input  logic [31:0]     value_real,
    input  logic [31:0]     value_imag,
    output logic            op_valid,
    input  logic            op_ready,
    output op_t             op,
    output logic [CA_W-1:0] op_addr
);

    localparam int QDEPTH = 2;

    op_t             q_op_reg   [QDEPTH];
    logic [CA_W-1:0] q_addr_reg [QDEPTH];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;

    logic            keep;
    op_t             dec_op;
    logic [CA_W-1:0] dec_addr;
    logic            push, pop;

    // classify the incoming word
    always_comb
    begin
        keep          = 1'b0;
        dec_op.kind   = OP_COEF;
        dec_op.re     = value_real;
        dec_op.im     = value_imag;
        dec_addr      = CA_W'(32'(position));
        if (command == CMD_LOAD)
        begin
            keep     = (32'(row_index) < OUT_LEN) && (32'(position) < COLUMN_LEN);
            dec_addr = CA_W'(32'(row_index) * COLUMN_LEN + 32'(position));
        end
        else
        begin
            keep = 32'(position) < COLUMN_LEN;
            if (32'(position) == COLUMN_LEN - 1)
            begin
                dec_op.kind = OP_RUN;
            end
            else
            begin
                dec_op.kind = OP_SAMPLE;
            end
        end
    end

    assign item_ready = count_reg != 2'(QDEPTH);
    assign push       = item_valid && item_ready && keep;
    assign op_valid   = count_reg != 2'd0;
    assign pop        = op_valid && op_ready;
    assign op         = q_op_reg[rd_ptr_reg];
    assign op_addr    = q_addr_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    // advance queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // hold queued words
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_op_reg[wr_ptr_reg]   <= dec_op;
            q_addr_reg[wr_ptr_reg] <= dec_addr;
        end
    end

endmodule

[rtl/ccedf_mac.sv]
module ccedf_mac
    import ccedf_pkg::*;
#(
    parameter int COLUMN_LEN = COLUMN_LEN_DEF,
    parameter int OUT_LEN    = OUT_LEN_DEF,
    parameter int CA_W       = $clog2(OUT_LEN * COLUMN_LEN)
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            op_valid,
    output logic            op_ready,
    input  op_t             op,
    input  logic [CA_W-1:0] op_addr,
    output logic            row_valid,
    input  logic            row_ready,
    output row_res_t        row_res
);

    localparam int DEPTH = OUT_LEN * COLUMN_LEN;
    localparam int POS_W = $clog2(COLUMN_LEN);
    localparam int ROW_W = $clog2(OUT_LEN);
    localparam int ACC_W = 38 + POS_W;

    typedef enum logic [3:0] {
        M_IDLE  = 4'b0001,
        M_RUN   = 4'b0010,
        M_DRAIN = 4'b0100,
        M_SEND  = 4'b1000
    } mac_state_t;

    mac_state_t state_reg, state_next;

    logic [63:0] coef_mem [DEPTH];
    logic [63:0] col_mem  [COLUMN_LEN];

    logic [CA_W-1:0]  caddr_reg;
    logic [POS_W-1:0] tap_reg;
    logic [ROW_W-1:0] row_reg;
    logic             v1_reg, v2_reg;
    logic [63:0]      coef_q_reg, col_q_reg;
    logic signed [63:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [ACC_W-1:0] acc_re_reg, acc_im_reg;

    logic issue, start_row, tap_last, row_last;
    logic signed [63:0] r_rr, r_ii, r_ri, r_ir;
    logic signed [35:0] t_rr, t_ii, t_ri, t_ir;

    assign issue     = state_reg == M_RUN;
    assign tap_last  = tap_reg == POS_W'(COLUMN_LEN - 1);
    assign row_last  = row_reg == ROW_W'(OUT_LEN - 1);
    assign op_ready  = state_reg == M_IDLE;
    assign row_valid = state_reg == M_SEND;
    assign start_row = (op_valid && op_ready && op.kind == OP_RUN)
                       || (row_valid && row_ready && !row_last);

    // sequence rows and taps
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            M_IDLE:
            begin
                if (op_valid && op.kind == OP_RUN)
                begin
                    state_next = M_RUN;
                end
            end
            M_RUN:
            begin
                if (tap_last)
                begin
                    state_next = M_DRAIN;
                end
            end
            M_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                begin
                    state_next = M_SEND;
                end
            end
            M_SEND:
            begin
                if (row_ready)
                begin
                    state_next = row_last ? M_IDLE : M_RUN;
                end
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            caddr_reg <= '0;
            tap_reg   <= '0;
            row_reg   <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v1_reg    <= issue;
            v2_reg    <= v1_reg;
            if (op_valid && op_ready && op.kind == OP_RUN)
            begin
                caddr_reg <= '0;
                tap_reg   <= '0;
                row_reg   <= '0;
            end
            else
            begin
                if (issue)
                begin
                    caddr_reg <= caddr_reg + CA_W'(1);
                    tap_reg   <= tap_last ? '0 : tap_reg + POS_W'(1);
                end
                if (row_valid && row_ready)
                begin
                    row_reg <= row_reg + ROW_W'(1);
                end
            end
        end
    end

    // write stores, read one tap
    always_ff @(posedge clk)
    begin
        if (op_valid && op_ready && op.kind == OP_COEF)
        begin
            coef_mem[op_addr] <= {op.re, op.im};
        end
        if (op_valid && op_ready && op.kind != OP_COEF)
        begin
            col_mem[op_addr[POS_W-1:0]] <= {op.re, op.im};
        end
        if (issue)
        begin
            coef_q_reg <= coef_mem[caddr_reg];
            col_q_reg  <= col_mem[tap_reg];
        end
    end

    // complex products
    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            p_rr_reg <= $signed(coef_q_reg[63:32]) * $signed(col_q_reg[63:32]);
            p_ii_reg <= $signed(coef_q_reg[31:0])  * $signed(col_q_reg[31:0]);
            p_ri_reg <= $signed(coef_q_reg[63:32]) * $signed(col_q_reg[31:0]);
            p_ir_reg <= $signed(coef_q_reg[31:0])  * $signed(col_q_reg[63:32]);
        end
    end

    // round each product to Q4.28
    always_comb
    begin
        r_rr = p_rr_reg + 64'sd134217728;
        r_ii = p_ii_reg + 64'sd134217728;
        r_ri = p_ri_reg + 64'sd134217728;
        r_ir = p_ir_reg + 64'sd134217728;
        t_rr = r_rr[63:28];
        t_ii = r_ii[63:28];
        t_ri = r_ri[63:28];
        t_ir = r_ir[63:28];
    end

    // accumulate
    always_ff @(posedge clk)
    begin
        if (start_row)
        begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_re_reg <= acc_re_reg + ACC_W'(t_rr) - ACC_W'(t_ii);
            acc_im_reg <= acc_im_reg + ACC_W'(t_ri) + ACC_W'(t_ir);
        end
    end

    function automatic logic [31:0] sat_acc(input logic [ACC_W-1:0] a);
        logic [31:0] r;
        if (!a[ACC_W-1] && (|a[ACC_W-2:31]))
        begin
            r = 32'h7FFF_FFFF;
        end
        else if (a[ACC_W-1] && !(&a[ACC_W-2:31]))
        begin
            r = 32'h8000_0000;
        end
        else
        begin
            r = a[31:0];
        end
        return r;
    endfunction

    assign row_res.re    = sat_acc(acc_re_reg);
    assign row_res.im    = sat_acc(acc_im_reg);
    assign row_res.index = 4'(row_reg);
    assign row_res.last  = row_last;

endmodule

[rtl/ccedf_floor.sv]
module ccedf_floor
    import ccedf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        row_valid,
    output logic        row_ready,
    input  row_res_t    row_res,
    input  logic [31:0] min_density,
    input  logic        final_pass,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [3:0]  out_index,
    output logic [31:0] out_real,
    output logic [31:0] out_imag,
    output logic [31:0] out_density,
    output logic        last_of_column
);

    localparam int DIV_STEPS = 64;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    typedef enum logic [6:0] {
        F_IDLE = 7'b0000001,
        F_SQ   = 7'b0000010,
        F_CMP  = 7'b0000100,
        F_SQRT = 7'b0001000,
        F_MUL  = 7'b0010000,
        F_DIV  = 7'b0100000,
        F_DONE = 7'b1000000
    } floor_state_t;

    floor_state_t state_reg, state_next;

    logic [31:0] x_re_reg, x_im_reg, md_reg;
    logic [3:0]  idx_reg;
    logic        last_reg;
    logic [63:0] sq_re_reg, sq_im_reg, e_reg;
    logic [63:0] sq_x_reg, sq_r_reg, sq_bit_reg;
    logic        sel_reg, comp_reg;
    logic [31:0] a_reg, g_reg;
    logic [63:0] div_n_reg;
    logic [31:0] div_rem_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic [31:0] res_re_reg, res_im_reg, dens_reg;

    logic [63:0] e_sum, m_val, sq_sum, sq_r_step;
    logic        sq_ge, sq_done;
    logic [32:0] div_sh;
    logic        div_ge, div_done;
    logic [31:0] div_rem_step, mag, cur_x, scaled;
    logic [63:0] div_n_step, prod;

    assign row_ready      = state_reg == F_IDLE;
    assign result_valid   = state_reg == F_DONE;
    assign out_index      = idx_reg;
    assign out_real       = res_re_reg;
    assign out_imag       = res_im_reg;
    assign out_density    = dens_reg;
    assign last_of_column = last_reg;

    // square root step
    always_comb
    begin
        sq_sum    = sq_r_reg + sq_bit_reg;
        sq_ge     = sq_x_reg >= sq_sum;
        sq_r_step = sq_ge ? (sq_r_reg >> 1) + sq_bit_reg : sq_r_reg >> 1;
        sq_done   = sq_bit_reg == 64'd1;
    end

    // restoring divide step, then clamp the quotient
    always_comb
    begin
        div_sh       = {div_rem_reg, div_n_reg[63]};
        div_ge       = div_sh >= {1'b0, g_reg};
        div_rem_step = div_ge ? 32'(div_sh - {1'b0, g_reg}) : div_sh[31:0];
        div_n_step   = {div_n_reg[62:0], div_ge};
        div_done     = dcnt_reg == DCNT_W'(DIV_STEPS - 1);
        cur_x        = comp_reg ? x_im_reg : x_re_reg;
        if (cur_x[31])
        begin
            scaled = (|div_n_step[63:31]) ? 32'h8000_0000 : 32'(-div_n_step[31:0]);
        end
        else
        begin
            scaled = (|div_n_step[63:31]) ? 32'h7FFF_FFFF : div_n_step[31:0];
        end
        mag   = cur_x[31] ? 32'(-cur_x) : cur_x;
        prod  = 64'(mag) * 64'(a_reg);
        e_sum = sq_re_reg + sq_im_reg;
        m_val = {md_reg, 32'd0};
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (row_valid)
                begin
                    state_next = final_pass ? F_SQ : F_DONE;
                end
            end
            F_SQ:
            begin
                state_next = F_CMP;
            end
            F_CMP:
            begin
                state_next = (e_sum >= m_val) ? F_DONE : F_SQRT;
            end
            F_SQRT:
            begin
                if (sq_done)
                begin
                    if (sel_reg)
                    begin
                        state_next = F_MUL;
                    end
                    else if (e_reg == 64'd0)
                    begin
                        state_next = F_DONE;
                    end
                end
            end
            F_MUL:
            begin
                state_next = F_DIV;
            end
            F_DIV:
            begin
                if (div_done)
                begin
                    state_next = comp_reg ? F_DONE : F_MUL;
                end
            end
            F_DONE:
            begin
                if (result_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // floor datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            F_IDLE:
            begin
                x_re_reg   <= row_res.re;
                x_im_reg   <= row_res.im;
                idx_reg    <= row_res.index;
                last_reg   <= row_res.last;
                md_reg     <= min_density;
                res_re_reg <= row_res.re;
                res_im_reg <= row_res.im;
                dens_reg   <= 32'd0;
            end
            F_SQ:
            begin
                sq_re_reg <= 64'($signed(x_re_reg)) * 64'($signed(x_re_reg));
                sq_im_reg <= 64'($signed(x_im_reg)) * 64'($signed(x_im_reg));
            end
            F_CMP:
            begin
                e_reg      <= e_sum;
                dens_reg   <= e_sum[63:32];
                sq_x_reg   <= m_val;
                sq_r_reg   <= 64'd0;
                sq_bit_reg <= 64'h4000_0000_0000_0000;
                sel_reg    <= 1'b0;
            end
            F_SQRT:
            begin
                if (sq_done && !sel_reg)
                begin
                    // floor root done: keep it, start the magnitude root
                    dens_reg   <= md_reg;
                    a_reg      <= sq_r_step[31:0];
                    res_re_reg <= sq_r_step[31] ? 32'h7FFF_FFFF : sq_r_step[31:0];
                    res_im_reg <= 32'd0;
                    sq_x_reg   <= e_reg;
                    sq_r_reg   <= 64'd0;
                    sq_bit_reg <= 64'h4000_0000_0000_0000;
                    sel_reg    <= 1'b1;
                end
                else
                begin
                    sq_x_reg   <= sq_ge ? sq_x_reg - sq_sum : sq_x_reg;
                    sq_r_reg   <= sq_r_step;
                    sq_bit_reg <= sq_bit_reg >> 2;
                    if (sq_done)
                    begin
                        dens_reg <= md_reg;
                        g_reg    <= sq_r_step[31:0];
                        comp_reg <= 1'b0;
                    end
                end
            end
            F_MUL:
            begin
                div_n_reg   <= prod + 64'(g_reg >> 1);
                div_rem_reg <= 32'd0;
                dcnt_reg    <= '0;
            end
            F_DIV:
            begin
                div_n_reg   <= div_n_step;
                div_rem_reg <= div_rem_step;
                dcnt_reg    <= dcnt_reg + DCNT_W'(1);
                if (div_done)
                begin
                    comp_reg <= 1'b1;
                    if (comp_reg)
                    begin
                        res_im_reg <= scaled;
                    end
                    else
                    begin
                        res_re_reg <= scaled;
                    end
                end
            end
            F_DONE:
            begin
                dens_reg <= dens_reg;
            end
            default:
            begin
                dens_reg <= dens_reg;
            end
        endcase
    end

endmodule

[rtl/complex_column_evolve_density_floor_core.sv]
// Loads and non-final samples: accepted one word per cycle while the two-word queue has room.
// Last sample of a column: OUT_LEN rows, one after another through the shared MAC cell.
// With final_pass set, a row below the floor takes two 32-step square roots and two 64-step
// divides in the floor unit (only the floor root, and no divide, if its energy is zero); other rows keep their values.
// rst_n clears control state and the configuration registers; stores and datapath registers are not cleared.
module complex_column_evolve_density_floor_core
    import ccedf_pkg::*;
#(
    parameter int COLUMN_LEN = COLUMN_LEN_DEF,
    parameter int OUT_LEN    = OUT_LEN_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic        command,
    input  logic [3:0]  row_index,
    input  logic [4:0]  position,
    input  logic [31:0] value_real,
    input  logic [31:0] value_imag,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [3:0]  out_index,
    output logic [31:0] out_real,
    output logic [31:0] out_imag,
    output logic [31:0] out_density,
    output logic        last_of_column
);

    localparam int CA_W = $clog2(OUT_LEN * COLUMN_LEN);

    logic [31:0]     min_density_reg;
    logic            final_pass_reg;
    logic            cfg_wr;
    logic            op_valid, op_ready, row_valid, row_ready;
    op_t             op;
    logic [CA_W-1:0] op_addr;
    row_res_t        row_res;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_density_reg <= 32'd0;
            final_pass_reg  <= 1'b0;
        end
        else if (cfg_wr)
        begin
            if (32'(paddr[2]) == REG_MIN_DENSITY)
            begin
                min_density_reg <= pwdata;
            end
            else if (32'(paddr[2]) == REG_FINAL_PASS)
            begin
                final_pass_reg <= pwdata[0];
            end
        end
    end

    assign prdata = (32'(paddr[2]) == REG_MIN_DENSITY) ? min_density_reg
                                                         : {31'd0, final_pass_reg};

    ccedf_front #(
        .COLUMN_LEN (COLUMN_LEN),
        .OUT_LEN    (OUT_LEN),
        .CA_W       (CA_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .command    (command),
        .row_index  (row_index),
        .position   (position),
        .value_real (value_real),
        .value_imag (value_imag),
        .op_valid   (op_valid),
        .op_ready   (op_ready),
        .op         (op),
        .op_addr    (op_addr)
    );

    ccedf_mac #(
        .COLUMN_LEN (COLUMN_LEN),
        .OUT_LEN    (OUT_LEN),
        .CA_W       (CA_W)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_ready  (op_ready),
        .op        (op),
        .op_addr   (op_addr),
        .row_valid (row_valid),
        .row_ready (row_ready),
        .row_res   (row_res)
    );

    ccedf_floor u_floor (
        .clk            (clk),
        .rst_n          (rst_n),
        .row_valid      (row_valid),
        .row_ready      (row_ready),
        .row_res        (row_res),
        .min_density    (min_density_reg),
        .final_pass     (final_pass_reg),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .out_index      (out_index),
        .out_real       (out_real),
        .out_imag       (out_imag),
        .out_density    (out_density),
        .last_of_column (last_of_column)
    );

endmodule

[rtl/ccedf_checker.sv]
module ccedf_checker
    import ccedf_pkg::*;
#(
    parameter int OUT_LEN = OUT_LEN_DEF
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        pready,
    input logic        result_valid,
    input logic        result_ready,
    input logic [3:0]  out_index,
    input logic [31:0] out_real,
    input logic [31:0] out_imag,
    input logic [31:0] out_density,
    input logic        last_of_column
);

    // configuration port never stalls
    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

    // stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(out_real)
            && $stable(out_imag) && $stable(out_density) && $stable(out_index))
        else $error("stalled result changed");

    // column end marks the last row
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_of_column |-> out_index == 4'(OUT_LEN - 1))
        else $error("last_of_column on wrong row");

    // only the last row carries the column end
    a_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && out_index != 4'(OUT_LEN - 1) && OUT_LEN <= 16 |-> !last_of_column)
        else $error("early column end");

endmodule

bind complex_column_evolve_density_floor_core ccedf_checker #(.OUT_LEN(OUT_LEN)) u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .pready         (pready),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .out_index      (out_index),
    .out_real       (out_real),
    .out_imag       (out_imag),
    .out_density    (out_density),
    .last_of_column (last_of_column)
);
